/* src/histogram_median_defines.svh */
// Assertion macros shared by the histogram median RTL.
`ifndef HISTOGRAM_MEDIAN_DEFINES_SVH
`define HISTOGRAM_MEDIAN_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define HM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define HM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HM_ASSERT(lbl, clk, rst_n, prop, msg)
`define HM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* src/hmed_pkg.sv */
`timescale 1ns / 1ps

package hmed_pkg;

    // Default sizing of the bin store.
    localparam int NUM_BINS_DEF   = 256;
    localparam int COUNT_BITS_DEF = 32;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd2;

    // Configuration reset values.
    localparam logic signed [15:0] RANGE_LOW_RST  = 16'sd0;
    localparam logic signed [15:0] RANGE_HIGH_RST = 16'sd255;
    localparam logic [15:0]        BIN_WIDTH_RST  = 16'd1;

    // Input request: mode 0 adds a sample, mode 1 finishes the run.
    typedef struct packed {
        logic               mode;
        logic signed [15:0] sample;
    } t_in_req;

    // Output request: one per finish.
    typedef struct packed {
        logic signed [15:0] median_value;
        logic               median_found;
        logic [31:0]        sample_total;
    } t_out_req;

endpackage

/* src/histogram_median.sv */
`timescale 1ns / 1ps
`include "histogram_median_defines.svh"

// Streaming histogram with median readout. Add requests (mode 0) drop a signed sample into
// bin (sample - range_low) / bin_width of a bin store of NUM_BINS saturating counters
// with one read and one write port; out-of-range samples are dropped. An accepted add
// is qualified, then goes through the bit-serial divider, the bin store read and the
// write back before the next request can be taken. A sample that is dropped before the
// divider leaves the block idle. A finish request (mode 1) walks and clears every bin
// through the store's one read and one write port, one bin a cycle, then waits for the
// output register to drain; it returns range_low + index * bin_width of the bin where
// twice the running sum first exceeds the total, a found flag and the total. After
// reset the block sweeps every bin of the store to zero and stalls input meanwhile;
// configuration writes are taken at any time and the config port is always ready, but
// the registers should only change while the block is idle.
module histogram_median #(
    parameter int NUM_BINS   = hmed_pkg::NUM_BINS_DEF,
    parameter int COUNT_BITS = hmed_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  hmed_pkg::t_in_req              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output hmed_pkg::t_out_req             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [hmed_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]                    i_cfg_data
);
    import hmed_pkg::*;

    localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ACC_W = COUNT_BITS + 2;
    localparam logic [16:0]      BIN_LIM  = 17'(NUM_BINS);
    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHECK,
        S_INC,
        S_WALK,
        S_DRAIN,
        S_EMIT
    } t_state;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Configuration and control state
    t_state                  r_state;
    logic signed [15:0]      r_range_low;
    logic signed [15:0]      r_range_high;
    logic [15:0]             r_bin_width;
    logic [COUNT_BITS-1:0]   r_total;
    logic                    r_out_valid;
    t_out_req                r_out_data;

    // Divider and walk registers
    logic [15:0]             r_off;
    logic [15:0]             r_dvd;
    logic [15:0]             r_rem;
    logic [15:0]             r_quo;
    logic [3:0]              r_cnt;
    logic [IDX_W-1:0]        r_addr;
    logic [IDX_W-1:0]        r_bin_idx;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_vld;
    logic [ACC_W-1:0]        r_acc;
    logic [COUNT_BITS-1:0]   r_tot_snap;
    logic                    r_found;
    logic [IDX_W-1:0]        r_med_idx;

    // Bin store
    logic [COUNT_BITS-1:0]   r_bins [NUM_BINS];
    logic [COUNT_BITS-1:0]   r_rd_data;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [COUNT_BITS-1:0]   mem_wdata;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;

    // Combinational helpers
    logic                    in_take;
    logic                    out_free;
    logic signed [17:0]      n_off;
    logic signed [17:0]      n_span;
    logic                    span_bad;
    logic [16:0]             n_shift;
    logic [16:0]             n_diff;
    logic                    n_qbit;
    logic [17:0]             n_lim;
    logic                    bin_ok;
    logic [ACC_W-1:0]        n_sum;
    logic                    n_hit;
    logic [31:0]             n_prod;
    logic signed [15:0]      n_median;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // Qualify a sample against the range
    assign n_off    = 18'($signed(i_in_data.sample)) - 18'(r_range_low);
    assign n_span   = 18'(r_range_high) - 18'(r_range_low) + 18'sd1;
    assign span_bad = n_span[17] || (n_span == 18'sd0);

    // One restoring divide step
    assign n_shift = {r_rem, r_dvd[15]};
    assign n_diff  = n_shift - {1'b0, r_bin_width};
    assign n_qbit  = (n_shift >= {1'b0, r_bin_width});

    // Bin index is valid when index*width + width fits the span and the index is below NUM_BINS
    assign n_lim  = {2'b00, r_off} - {2'b00, r_rem} + {2'b00, r_bin_width};
    assign bin_ok = (n_lim <= n_span) && ({1'b0, r_quo} < BIN_LIM);

    // Accumulate one bin of the walk
    assign n_sum = r_acc + ACC_W'(r_rd_data);
    assign n_hit = r_rd_vld && !r_found && ({n_sum, 1'b0} > (ACC_W + 1)'(r_tot_snap));

    // Scale the median bin index
    assign n_prod   = 32'(r_med_idx) * 32'(r_bin_width);
    assign n_median = r_range_low + (r_found ? n_prod[15:0] : 16'sd0);

    // Drive bin store ports
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = r_addr;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_CHECK: begin
                mem_re    = bin_ok;
                mem_raddr = r_quo[IDX_W-1:0];
            end
            S_INC: begin
                mem_we    = 1'b1;
                mem_waddr = r_bin_idx;
                mem_wdata = sat_inc(r_rd_data);
            end
            S_WALK: begin
                mem_we = 1'b1;
                mem_re = 1'b1;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Bin store with registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bins[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_bins[mem_raddr];
        end
    end

    // Sequencer, counters and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_found      <= 1'b0;
            r_range_low  <= RANGE_LOW_RST;
            r_range_high <= RANGE_HIGH_RST;
            r_bin_width  <= BIN_WIDTH_RST;
        end else begin
            // take configuration writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANGE_LOW:  r_range_low  <= i_cfg_data;
                    CFG_RANGE_HIGH: r_range_high <= i_cfg_data;
                    CFG_BIN_WIDTH:  r_bin_width  <= i_cfg_data;
                    default: ;
                endcase
            end

            // drop the output once taken, unless a new result replaces it
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            // fold in the bin read during the walk
            if (r_rd_vld && !r_found) begin
                r_acc <= n_sum;
                if (n_hit) begin
                    r_found   <= 1'b1;
                    r_med_idx <= r_rd_idx;
                end
            end
            r_rd_vld <= (r_state == S_WALK);
            r_rd_idx <= r_addr;

            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_BIN) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_take) begin
                        if (i_in_data.mode) begin
                            r_addr     <= '0;
                            r_acc      <= '0;
                            r_found    <= 1'b0;
                            r_tot_snap <= r_total;
                            r_total    <= '0;
                            r_state    <= S_WALK;
                        end else if (!n_off[17] && !span_bad && (r_bin_width != 16'd0)) begin
                            r_off   <= n_off[15:0];
                            r_dvd   <= n_off[15:0];
                            r_rem   <= '0;
                            r_quo   <= '0;
                            r_cnt   <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_dvd <= {r_dvd[14:0], 1'b0};
                    r_rem <= n_qbit ? n_diff[15:0] : n_shift[15:0];
                    r_quo <= {r_quo[14:0], n_qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_bin_idx <= r_quo[IDX_W-1:0];
                    r_state   <= bin_ok ? S_INC : S_IDLE;
                end
                S_INC: begin
                    r_total <= sat_inc(r_total);
                    r_state <= S_IDLE;
                end
                S_WALK: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_BIN) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid               <= 1'b1;
                        r_out_data.median_value   <= n_median;
                        r_out_data.median_found   <= r_found;
                        r_out_data.sample_total   <= 32'(r_tot_snap);
                        r_state                   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A result appears only at the end of a finish walk
    `HM_ASSERT(a_out_from_emit, i_clk, i_rst_n,
        $rose(o_out_valid) |-> $past(r_state == S_EMIT), "result raised outside emit")

    // A counted sample bumps the total unless it has saturated
    `HM_ASSERT(a_total_inc, i_clk, i_rst_n,
        ((r_state == S_INC) && !(&r_total)) |=> (r_total == $past(r_total) + 1'b1),
        "total did not advance")

    // A finish request restarts the total
    `HM_ASSERT(a_finish_clears, i_clk, i_rst_n,
        (in_take && i_in_data.mode) |=> ((r_total == '0) && (r_state == S_WALK)),
        "finish did not clear total")

    // Input stays stalled while the store is swept after reset
    `HM_ASSERT_ALWAYS(a_clear_stall, i_clk,
        (r_state == S_CLEAR) |-> o_in_stall, "input taken during clear")

endmodule

/* tb/histogram_median_test.sv */
`timescale 1ns / 1ps

module histogram_median_test;
    import hmed_pkg::*;

    localparam int NBINS = NUM_BINS_DEF;
    localparam int CNT_W = COUNT_BITS_DEF;

    // Request kinds and the register index that maps to nothing
    localparam logic MODE_ADD    = 1'b0;
    localparam logic MODE_FINISH = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam int ITEM_TARGET   = 1500;
    localparam int SETTLE_CYCLES = 40;          // covers an add in flight through the divider and bin store
    localparam int FINAL_CYCLES  = NBINS + 60;
    localparam int LONG_HOLD     = 1200;
    localparam int CYCLE_LIMIT   = 2000000;

    // Running histogram, median readout and mismatch bookkeeping
    class median_tracker;
        logic signed [15:0] low_q;
        logic signed [15:0] high_q;
        logic [15:0]        width_q;
        logic [CNT_W-1:0]   bin_q [NBINS];
        logic [CNT_W-1:0]   total_q;
        t_out_req           medians_due[$];
        int                 errors;
        int                 counted;

        function new();
            low_q   = RANGE_LOW_RST;
            high_q  = RANGE_HIGH_RST;
            width_q = BIN_WIDTH_RST;
            foreach (bin_q[i]) bin_q[i] = '0;
            total_q = '0;
            errors  = 0;
            counted = 0;
        endfunction

        task report(input string msg);
            $display("ERROR @%0t: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
            case (idx)
                CFG_RANGE_LOW:  low_q   = val;
                CFG_RANGE_HIGH: high_q  = val;
                CFG_BIN_WIDTH:  width_q = val;
                default: ;
            endcase
        endfunction

        // Number of bins the current registers describe, capped at the store size
        function int bins_in_use();
            int lo, hi, w, span, nb;
            lo = $signed(low_q);
            hi = $signed(high_q);
            w  = width_q;
            span = hi - lo + 1;
            if (w == 0 || span <= 0) return 0;
            nb = span / w;
            return (nb > NBINS) ? NBINS : nb;
        endfunction

        // Apply one accepted request; returns 1 when it counted or finished
        function bit take_request(input t_in_req req);
            int lo, w, smp, off, nb, idx, med, i;
            longint run_sum, tot;
            t_out_req res;
            counted++;
            lo = $signed(low_q);
            w  = width_q;
            if (req.mode == MODE_ADD) begin
                smp = $signed(req.sample);
                off = smp - lo;
                nb  = bins_in_use();
                if (nb <= 0 || off < 0) return 1'b0;
                idx = off / w;
                if (idx >= nb) return 1'b0;
                if (bin_q[idx] != '1) bin_q[idx]++;
                if (total_q != '1) total_q++;
                return 1'b1;
            end
            // Walk every bin, including stale ones, until half the total is passed
            tot = total_q;
            run_sum = 0;
            res.median_value = low_q;
            res.median_found = 1'b0;
            res.sample_total = total_q;
            for (i = 0; i < NBINS; i++) begin
                run_sum += bin_q[i];
                if (2 * run_sum > tot) begin
                    med = lo + i * w;
                    res.median_value = med[15:0];
                    res.median_found = 1'b1;
                    break;
                end
            end
            medians_due.push_back(res);
            foreach (bin_q[j]) bin_q[j] = '0;
            total_q = '0;
            return 1'b1;
        endfunction

        task check_median(input t_out_req got);
            t_out_req want;
            if (medians_due.size() == 0) begin
                report($sformatf("result with none pending: value %0d found %0b total %0d",
                                 got.median_value, got.median_found, got.sample_total));
                return;
            end
            want = medians_due.pop_front();
            if (got.median_value !== want.median_value)
                report($sformatf("median_value %0d, want %0d",
                                 got.median_value, want.median_value));
            if (got.median_found !== want.median_found)
                report($sformatf("median_found %0b, want %0b",
                                 got.median_found, want.median_found));
            if (got.sample_total !== want.sample_total)
                report($sformatf("sample_total %0d, want %0d",
                                 got.sample_total, want.sample_total));
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_req              i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_req             o_out_data;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    median_tracker sb;
    bit            hold_pending = 1'b0;
    int            burst_left = 0;
    int unsigned   cycle_count = 0;

    histogram_median uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("histogram_median verification failed");
            $finish;
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_median(o_out_data);
    end

    // Result side: stall in random styles, with one long hold-off on request
    initial begin : out_side
        int style, style_left, k;
        style = 0;
        style_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                for (k = 0; k < LONG_HOLD; k++) @(posedge i_clk);
            end
            if (style_left == 0) begin
                style = $urandom_range(0, 2);
                style_left = $urandom_range(20, 300);
            end
            style_left--;
            case (style)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Drop valid and wait before the next request
    task automatic hold_input(input int n);
        i_in_valid <= 1'b0;
        repeat ((n < 1) ? 1 : n) @(posedge i_clk);
    endtask

    // Offer one request, then advance the burst pacing
    task automatic send_req(input t_in_req req);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        void'(sb.take_request(req));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_input($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic add(input logic [15:0] s);
        t_in_req req;
        req.mode   = MODE_ADD;
        req.sample = s;
        send_req(req);
    endtask

    task automatic finish_run(input logic [15:0] s);
        t_in_req req;
        req.mode   = MODE_FINISH;
        req.sample = s;
        send_req(req);
    endtask

    // Wait until every median has arrived, then let the pipeline empty
    task automatic drain(input int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.medians_due.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    task automatic cfg_close();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_ranges(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [15:0] w);
        drain(SETTLE_CYCLES);
        cfg_write(CFG_RANGE_LOW, lo);
        cfg_write(CFG_RANGE_HIGH, hi);
        cfg_write(CFG_BIN_WIDTH, w);
        cfg_close();
    endtask

    // Mostly in-range samples, some at the edges, some anywhere
    function automatic logic [15:0] pick_sample();
        int lo, hi, r;
        lo = $signed(sb.low_q);
        hi = $signed(sb.high_q);
        r  = $urandom_range(0, 19);
        if (r < 2) return 16'($urandom);
        if (r == 2) return 16'(lo - 1);
        if (r == 3) return 16'(hi + 1);
        if (hi < lo) return 16'($urandom);
        return 16'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    // Pick a new setting: mostly sane spans, sometimes raw bits, sometimes unchanged
    task automatic random_ranges();
        int w, nb, span, lo, hi;
        case ($urandom_range(0, 9))
            0: set_ranges(16'($urandom), 16'($urandom), 16'($urandom));
            1: drain(SETTLE_CYCLES);
            default: begin
                w  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
                                                 : $urandom_range(1, 4);
                nb = ($urandom_range(0, 2) == 0) ? $urandom_range(2, 12)
                                                 : $urandom_range(2, 300);
                span = nb * w;
                if (span > 65536) span = 65536;
                lo = -32768 + int'($urandom_range(0, 65536 - span));
                hi = lo + span - 1 + int'($urandom_range(0, w - 1));
                if (hi > 32767) hi = 32767;
                set_ranges(16'(lo), 16'(hi), 16'(w));
            end
        endcase
    endtask

    initial begin : stimulus
        int n;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_RANGE_LOW;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: empty finish, edges of the range, drops on both sides
        finish_run(16'h0000);
        add(16'sd0);
        add(16'sd255);
        add(-16'sd1);
        add(16'sd256);
        add(16'sh7FFF);
        add(16'sh8000);
        add(16'sd100);
        add(16'sd100);
        finish_run(16'hFFFF);

        // Unused register index leaves the setting alone
        drain(SETTLE_CYCLES);
        cfg_write(CFG_SPARE, 16'hFFFF);
        cfg_close();

        // Full span: bin count capped at the store size
        set_ranges(16'sh8000, 16'sh7FFF, 16'd1);
        add(16'sh8000);
        add(16'(-32768 + 255));
        add(16'(-32768 + 256));
        finish_run(16'h0000);

        // Widest bins: a single bin over the full span
        set_ranges(16'sh8000, 16'sh7FFF, 16'hFFFF);
        add(16'sd32766);
        add(16'sh7FFF);
        finish_run(16'h0000);

        // Zero width and inverted range drop everything
        set_ranges(16'sd0, 16'sd255, 16'd0);
        add(16'sd5);
        finish_run(16'h0000);
        set_ranges(16'sh7FFF, 16'sh8000, 16'd1);
        add(16'sd0);
        add(16'sh7FFF);
        finish_run(16'h0000);

        // Stale bins read out under a new setting; the median wraps
        set_ranges(16'sh8000, 16'sh7FFF, 16'd1);
        repeat (3) add(16'(-32768 + 200));
        drain(SETTLE_CYCLES);
        cfg_write(CFG_RANGE_LOW, 16'sd32700);
        cfg_write(CFG_BIN_WIDTH, 16'd255);
        cfg_close();
        finish_run(16'h0000);

        // Back-pressure: hold the result side while finishes pile up
        set_ranges(-16'sd100, 16'sd155, 16'd1);
        hold_pending = 1'b1;
        repeat (4) begin
            repeat (5) add(pick_sample());
            finish_run(16'($urandom));
        end

        // Random phases
        while (sb.counted < ITEM_TARGET) begin
            random_ranges();
            n = $urandom_range(20, 120);
            repeat (n) begin
                if ($urandom_range(0, 14) == 0) finish_run(16'($urandom));
                else add(pick_sample());
            end
            if ($urandom_range(0, 3) != 0) finish_run(16'($urandom));
        end

        drain(FINAL_CYCLES);
        if (sb.medians_due.size() != 0)
            sb.report($sformatf("%0d medians never arrived", sb.medians_due.size()));
        if (sb.errors == 0) begin
            $display("histogram_median verification clean");
        end else begin
            $display("histogram_median verification failed");
        end
        $finish;
    end

endmodule
